// File: rtl/core/vpp_pkg.sv
// vpp_pkg: shared codes and controller/datapath interface types for the
// vector pixel plotter. Used by vpp_ctrl, vpp_dp and vector_pixel_plotter.
// No dependencies.
package vpp_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned ColourW = 3;
  localparam int unsigned AddrW = 2 * CoordW;

  // transaction kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register offsets
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_CMD = 2'd1;
  localparam logic [1:0] REG_LATCH = 2'd2;
  localparam logic [1:0] REG_COLOUR = 2'd3;

  // mode codes
  localparam logic [7:0] MODE_STEP = 8'd0;
  localparam logic [7:0] MODE_LOAD_Y = 8'd1;
  localparam logic [7:0] MODE_LOAD_X = 8'd2;
  localparam logic [7:0] MODE_CLEAR = 8'd3;
  localparam logic [7:0] MODE_NONE = 8'hff;

  // command byte bits in step mode
  localparam int unsigned BIT_X_DOWN = 7;
  localparam int unsigned BIT_Y_DOWN = 6;
  localparam int unsigned BIT_X_STEP = 5;
  localparam int unsigned BIT_Y_STEP = 4;

  localparam logic [7:0] CLEAR_GO = 8'd0;
  localparam logic [7:0] LATCH_GO = 8'd7;
  localparam logic [4:0] FIX_PREFIX = 5'b11111;
  localparam logic [ColourW-1:0] COLOUR_RESERVED = 3'd7;
  localparam logic [ColourW-1:0] DRAW_RESET = 3'd7;

  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic sweep_en;  // write clear colour at the sweep address
  } vpp_cmd_t;

  typedef struct packed {
    logic fill_req;    // current input is a clear command
    logic sweep_last;  // sweep address at the last cell
  } vpp_sts_t;

endpackage

// File: rtl/core/vpp_ctrl.sv
// vpp_ctrl: controller state machine for the vector pixel plotter.
// Sequences store sweeps and handshakes; depends on vpp_pkg.
module vpp_ctrl
  import vpp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  output vpp_cmd_t cmd,
  input  vpp_sts_t sts
);

  typedef enum logic {
    ST_SWEEP,
    ST_IDLE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;
  logic   accept_read;

  // a read needs the output register free or emptied this cycle
  assign in_stall = (state_r != ST_IDLE) ||
                    ((in_op == OP_READ) && out_valid_r && out_stall);
  assign accept = in_valid && !in_stall;
  assign accept_read = accept && (in_op == OP_READ);

  assign cmd.accept = accept;
  assign cmd.sweep_en = (state_r == ST_SWEEP);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_SWEEP: begin
          if (sts.sweep_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && sts.fill_req) begin
            state_r <= ST_SWEEP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (accept_read) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/vpp_dp.sv
// vpp_dp: datapath of the vector pixel plotter: mode, cursor and colour
// registers, sweep counter and the 256x256 frame store. Depends on vpp_pkg.
module vpp_dp
  import vpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  vpp_cmd_t           cmd,
  output vpp_sts_t           sts,
  input  logic               in_op,
  input  logic [1:0]         in_reg_offset,
  input  logic [7:0]         in_wdata,
  input  logic [CoordW-1:0]  in_read_x,
  input  logic [CoordW-1:0]  in_read_y,
  output logic [ColourW-1:0] out_pixel_colour
);

  logic [7:0]         mode_r;
  logic [CoordW-1:0]  cursor_x_r;
  logic [CoordW-1:0]  cursor_y_r;
  logic [ColourW-1:0] draw_colour_r;
  logic [ColourW-1:0] clear_colour_r;
  logic               clear_fixed_r;
  logic [AddrW-1:0]   sweep_addr_r;
  logic [ColourW-1:0] rd_data_r;

  logic [ColourW-1:0] frame_mem [2**AddrW];

  logic               wr_en;
  logic               cmd_wr;
  logic [CoordW-1:0]  step_x;
  logic [CoordW-1:0]  step_y;
  logic               plot_we;

  assign wr_en = cmd.accept && (in_op == OP_WRITE);
  assign cmd_wr = wr_en && (in_reg_offset == REG_CMD);
  assign plot_we = cmd_wr && (mode_r == MODE_STEP);

  always_comb begin
    step_x = cursor_x_r;
    step_y = cursor_y_r;
    if (in_wdata[BIT_X_STEP]) begin
      step_x = in_wdata[BIT_X_DOWN] ? cursor_x_r - 1'b1 : cursor_x_r + 1'b1;
    end
    if (in_wdata[BIT_Y_STEP]) begin
      step_y = in_wdata[BIT_Y_DOWN] ? cursor_y_r - 1'b1 : cursor_y_r + 1'b1;
    end
  end

  assign sts.fill_req = (in_op == OP_WRITE) && (in_reg_offset == REG_CMD) &&
                        (mode_r == MODE_CLEAR) && (in_wdata == CLEAR_GO);
  assign sts.sweep_last = (sweep_addr_r == {AddrW{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      draw_colour_r <= DRAW_RESET;
      clear_colour_r <= '0;
      clear_fixed_r <= 1'b0;
      sweep_addr_r <= '0;
    end else begin
      // wraps back to zero at the end of every sweep
      if (cmd.sweep_en) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
      end
      if (wr_en) begin
        unique case (in_reg_offset)
          REG_MODE: mode_r <= in_wdata;
          REG_CMD: begin
            priority if (mode_r == MODE_STEP) begin
              cursor_x_r <= step_x;
              cursor_y_r <= step_y;
            end else if (mode_r == MODE_LOAD_Y) begin
              cursor_y_r <= in_wdata;
            end else if (mode_r == MODE_LOAD_X) begin
              cursor_x_r <= in_wdata;
            end else if (mode_r == MODE_CLEAR && in_wdata == CLEAR_GO) begin
              clear_fixed_r <= 1'b0;
            end else begin
            end
          end
          REG_LATCH: begin
            if (in_wdata == LATCH_GO && !clear_fixed_r) begin
              clear_colour_r <= draw_colour_r;
            end
          end
          REG_COLOUR: begin
            if (mode_r == MODE_STEP) begin
              draw_colour_r <= in_wdata[ColourW-1:0];
            end else if (in_wdata[7:3] == FIX_PREFIX &&
                         in_wdata[ColourW-1:0] != COLOUR_RESERVED) begin
              clear_colour_r <= in_wdata[ColourW-1:0];
              clear_fixed_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // single write port: sweep or plot, never both
  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      frame_mem[sweep_addr_r] <= clear_colour_r;
    end else if (plot_we) begin
      frame_mem[{step_y, step_x}] <= draw_colour_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_op == OP_READ) begin
      rd_data_r <= frame_mem[{in_read_y, in_read_x}];
    end
  end

  assign out_pixel_colour = rd_data_r;

endmodule

// File: rtl/core/vector_pixel_plotter.sv
// vector_pixel_plotter: register-driven pixel plotter over a 256x256 store
// of 3-bit colours. Top level; instantiates vpp_ctrl and vpp_dp, uses vpp_pkg.
//
// Usage:
//   in_* channel carries one transaction per accept: a register write
//   (in_op 0, in_reg_offset, in_wdata) or a pixel read (in_op 1,
//   in_read_x, in_read_y). Writes give no result; a read gives one result
//   on the out_* channel, out_pixel_colour, valid in the cycle after accept.
//   Throughput is one transaction per cycle while in_stall is low, set by
//   the single frame store port: a write or read completes at its accept edge.
//   A clear command (mode 3, data 0 on the command port) sweeps the store
//   one cell per cycle with in_stall high throughout.
//   After reset the same sweep writes colour 0 to every cell before the
//   first transaction is taken.
//   The result sits in an output register; while out_stall is high it is
//   held, writes are still taken, and a further read waits until the
//   held result leaves.
module vector_pixel_plotter
  import vpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [1:0]         in_reg_offset,
  input  logic [7:0]         in_wdata,
  input  logic [CoordW-1:0]  in_read_x,
  input  logic [CoordW-1:0]  in_read_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ColourW-1:0] out_pixel_colour
);

  vpp_cmd_t cmd;
  vpp_sts_t sts;

  vpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  vpp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_reg_offset    (in_reg_offset),
    .in_wdata         (in_wdata),
    .in_read_x        (in_read_x),
    .in_read_y        (in_read_y),
    .out_pixel_colour (out_pixel_colour)
  );

  // a read always shows its result on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_op == OP_READ) |=> out_valid)
    else $error("read result missing");

  // nothing is taken while the store is being swept
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_en |-> !cmd.accept)
    else $error("transaction accepted during sweep");

  // a clear command starts a sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.fill_req) |=> cmd.sweep_en)
    else $error("clear command did not start sweep");

  // a sweep runs until the last cell
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep_en && !sts.sweep_last) |=> cmd.sweep_en)
    else $error("sweep ended early");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for vector_pixel_plotter; keeps its own cursor,
// colours and frame store, and predicts every pixel read. Depends on vpp_pkg.
module tb;
  import vpp_pkg::*;

  localparam int unsigned Cells = 1 << AddrW;
  localparam int unsigned NumItems = 1200;
  localparam int unsigned MaxClears = 4;

  class frame_predictor;
    logic [7:0]         mode;
    logic [CoordW-1:0]  cur_x;
    logic [CoordW-1:0]  cur_y;
    logic [ColourW-1:0] draw;
    logic [ColourW-1:0] clear_col;
    bit                 clear_fixed;
    logic [ColourW-1:0] store [Cells];
    logic [ColourW-1:0] pending_colours [$];
    int unsigned        errors;

    function new();
      mode = MODE_NONE;
      cur_x = '0;
      cur_y = '0;
      draw = DRAW_RESET;
      clear_col = '0;
      clear_fixed = 1'b0;
      foreach (store[i]) store[i] = '0;
      errors = 0;
    endfunction

    task report(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    function void take_transaction(input logic op, input logic [1:0] off,
                                   input logic [7:0] d, input logic [CoordW-1:0] rx,
                                   input logic [CoordW-1:0] ry);
      if (op == OP_READ) begin
        pending_colours.push_back(store[{ry, rx}]);
        return;
      end
      case (off)
        REG_MODE: mode = d;
        REG_CMD: begin
          if (mode == MODE_STEP) begin
            if (d[BIT_X_STEP]) cur_x = d[BIT_X_DOWN] ? cur_x - 1'b1 : cur_x + 1'b1;
            if (d[BIT_Y_STEP]) cur_y = d[BIT_Y_DOWN] ? cur_y - 1'b1 : cur_y + 1'b1;
            store[{cur_y, cur_x}] = draw;
          end else if (mode == MODE_LOAD_Y) begin
            cur_y = d;
          end else if (mode == MODE_LOAD_X) begin
            cur_x = d;
          end else if (mode == MODE_CLEAR && d == CLEAR_GO) begin
            foreach (store[i]) store[i] = clear_col;
            clear_fixed = 1'b0;
          end
        end
        REG_LATCH: begin
          if (d == LATCH_GO && !clear_fixed) clear_col = draw;
        end
        default: begin
          if (mode == MODE_STEP) begin
            draw = d[ColourW-1:0];
          end else if (d[7:3] == FIX_PREFIX && d[ColourW-1:0] != COLOUR_RESERVED) begin
            clear_col = d[ColourW-1:0];
            clear_fixed = 1'b1;
          end
        end
      endcase
    endfunction

    task check_colour(input logic [ColourW-1:0] got);
      logic [ColourW-1:0] want;
      if (pending_colours.size() == 0) begin
        report($sformatf("pixel colour %0d with no read outstanding", got));
      end else begin
        want = pending_colours.pop_front();
        if (got !== want) report($sformatf("pixel colour %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = OP_WRITE;
  logic [1:0]         in_reg_offset = REG_MODE;
  logic [7:0]         in_wdata = '0;
  logic [CoordW-1:0]  in_read_x = '0;
  logic [CoordW-1:0]  in_read_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ColourW-1:0] out_pixel_colour;

  frame_predictor frames = new();
  int unsigned    sent = 0;
  int unsigned    phase = 0;
  int unsigned    gap_pct;
  int unsigned    stall_pct;
  int unsigned    clears_left = MaxClears;

  vector_pixel_plotter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_reg_offset   (in_reg_offset),
    .in_wdata        (in_wdata),
    .in_read_x       (in_read_x),
    .in_read_y       (in_read_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_colour(out_pixel_colour)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always_comb begin
    case (phase)
      1: begin
        gap_pct = 56;
        stall_pct = 0;
      end
      2: begin
        gap_pct = 0;
        stall_pct = 56;
      end
      3: begin
        gap_pct = 10;
        stall_pct = 10;
      end
      default: begin
        gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) frames.check_colour(out_pixel_colour);
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  task automatic send(input logic op, input logic [1:0] off, input logic [7:0] d,
                      input logic [CoordW-1:0] rx, input logic [CoordW-1:0] ry);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_reg_offset <= off;
    in_wdata <= d;
    in_read_x <= rx;
    in_read_y <= ry;
    do @(posedge clk); while (in_stall !== 1'b0);
    frames.take_transaction(op, off, d, rx, ry);
    sent++;
  endtask

  task automatic wr(input logic [1:0] off, input logic [7:0] d);
    send(OP_WRITE, off, d, rnd8(), rnd8());
  endtask

  task automatic rd(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    send(OP_READ, 2'($urandom), rnd8(), x, y);
  endtask

  // reads land on or next to the cursor so that plotted pixels get seen
  task automatic read_near();
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    x = frames.cur_x + CoordW'($urandom_range(0, 2)) - 1'b1;
    y = frames.cur_y + CoordW'($urandom_range(0, 2)) - 1'b1;
    rd(x, y);
  endtask

  task automatic random_burst();
    int unsigned k;
    logic        op;
    logic [1:0]  off;
    logic [7:0]  d;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      if (frames.mode != MODE_STEP) wr(REG_MODE, MODE_STEP);
      if ($urandom_range(0, 1)) wr(REG_COLOUR, rnd8());
      repeat ($urandom_range(1, 6)) wr(REG_CMD, rnd8());
      repeat ($urandom_range(1, 3)) read_near();
    end else if (k < 60) begin
      wr(REG_MODE, MODE_LOAD_Y);
      wr(REG_CMD, rnd8());
      wr(REG_MODE, MODE_LOAD_X);
      wr(REG_CMD, rnd8());
      if ($urandom_range(0, 1)) read_near();
    end else if (k < 72) begin
      if ($urandom_range(0, 1)) begin
        wr(REG_MODE, MODE_STEP);
        wr(REG_COLOUR, rnd8());
        wr(REG_LATCH, $urandom_range(0, 3) != 0 ? LATCH_GO : rnd8());
      end else begin
        wr(REG_MODE, 8'($urandom_range(1, 255)));
        wr(REG_COLOUR, {FIX_PREFIX, 3'($urandom)});
      end
    end else if (k < 77) begin
      wr(REG_MODE, MODE_CLEAR);
      if (clears_left > 0 && $urandom_range(0, 1)) begin
        clears_left--;
        wr(REG_CMD, CLEAR_GO);
      end else begin
        wr(REG_CMD, 8'($urandom_range(1, 255)));
      end
      repeat ($urandom_range(1, 3)) rd(rnd8(), rnd8());
    end else begin
      op = 1'($urandom);
      off = 2'($urandom);
      d = rnd8();
      // a stray clear would cost a full sweep; only the budgeted ones run
      if (op == OP_WRITE && off == REG_CMD && frames.mode == MODE_CLEAR && d == CLEAR_GO)
        d = 8'd1;
      send(op, off, d, rnd8(), rnd8());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // store reads zero, commands ignored with no valid mode, fixed clear colour
    rd(8'd255, 8'd255);
    wr(REG_CMD, 8'h30);
    wr(REG_COLOUR, 8'hfa);
    wr(REG_LATCH, LATCH_GO);
    // stepping with x wrapping in both directions, low command bits ignored
    wr(REG_MODE, MODE_STEP);
    wr(REG_COLOUR, 8'hfd);
    wr(REG_CMD, 8'hbf);
    wr(REG_CMD, 8'h70);
    wr(REG_CMD, 8'h0f);
    rd(8'd255, 8'd1);
    rd(8'd0, 8'd0);
    // cursor loads, colour 0xff and latch of a non-trigger value ignored
    wr(REG_MODE, MODE_LOAD_Y);
    wr(REG_CMD, 8'hff);
    wr(REG_MODE, MODE_LOAD_X);
    wr(REG_CMD, 8'h80);
    wr(REG_COLOUR, 8'hff);
    wr(REG_LATCH, 8'd6);
    wr(REG_MODE, MODE_STEP);
    wr(REG_CMD, 8'h10);
    // clear: nonzero data ignored, zero sweeps and unfixes the clear colour
    wr(REG_MODE, MODE_CLEAR);
    wr(REG_CMD, 8'h01);
    wr(REG_CMD, CLEAR_GO);
    rd(8'd128, 8'd0);
    wr(REG_LATCH, LATCH_GO);
    wr(REG_MODE, 8'h80);

    while (sent < NumItems) begin
      phase = (sent / 100) % 4;
      random_burst();
    end

    @(negedge clk) in_valid <= 1'b0;
    while (frames.pending_colours.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (frames.errors == 0 && frames.pending_colours.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // startup sweep plus up to five clear sweeps, with ample margin
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
